[rtl/nfcd_pkg.sv]
`timescale 1ns / 1ps

package nfcd_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
    localparam logic [7:0] START0_BYTE   = 8'h00;
    localparam logic [7:0] START1_BYTE   = 8'hFF;
    localparam logic [7:0] LIMIT_RESET   = 8'd254;

    localparam logic [1:0] KIND_TFI     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_GOOD    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PREAMBLE = 3'd1;
    localparam logic [2:0] ERR_START    = 3'd2;
    localparam logic [2:0] ERR_LCS      = 3'd3;
    localparam logic [2:0] ERR_LENGTH   = 3'd4;
    localparam logic [2:0] ERR_DCS      = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] payload_count;
        logic [2:0] error_code;
    } t_result;

endpackage

[rtl/nfc_frame_deframer.sv]
`timescale 1ns / 1ps

// NFC normal information frame parser. One received byte is taken per request on the
// input channel, and a new byte may be taken in every cycle unless a result waits on
// a full output register: each byte sits in an input register, the frame state machine
// handles it in that cycle, and any result lands in an output register, so a result is
// presented in the cycle after the state machine takes its byte at the earliest. TFI
// and payload bytes come out as they arrive, the postamble gives frame good or a data
// checksum error, and every failed check gives an error and restarts the preamble
// hunt. Header bytes that pass produce no result. Write payload_limit only while idle.
module nfc_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_payload_count,
    output logic [2:0] o_error_code
);
    import nfcd_pkg::*;

    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       take;
    logic       has_result;
    logic       out_space;
    t_result    result;
    t_result    out_result;

    assign take = stage_valid && (!has_result || out_space);

    nfcd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_rx_byte),
        .o_valid (stage_valid),
        .o_byte  (stage_byte),
        .i_take  (take)
    );

    nfcd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (stage_byte),
        .i_take        (take),
        .o_has_result  (has_result),
        .o_result      (result)
    );

    nfcd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid && has_result),
        .o_ready  (out_space),
        .i_result (result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_data_byte     = out_result.data_byte;
    assign o_payload_count = out_result.payload_count;
    assign o_error_code    = out_result.error_code;

    // error results carry a nonzero code and nothing else
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ERROR |->
            o_error_code != ERR_NONE && o_data_byte == 8'd0 && o_payload_count == 8'd0)
        else $error("error result without code");

    // data and good results carry no error code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_ERROR |-> o_error_code == ERR_NONE)
        else $error("error code on non-error result");

    // data bytes never report a payload count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_TFI || o_kind == KIND_PAYLOAD) |->
            o_payload_count == 8'd0)
        else $error("payload count on data byte");

    // a byte is only consumed when its result has room
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && has_result |-> out_space)
        else $error("result dropped");

endmodule

[rtl/nfcd_in_reg.sv]
`timescale 1ns / 1ps

module nfcd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);
    import nfcd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

[rtl/nfcd_parser.sv]
`timescale 1ns / 1ps

module nfcd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic [7:0]       i_byte,
    input  logic             i_take,
    output logic             o_has_result,
    output nfcd_pkg::t_result o_result
);
    import nfcd_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_SC0  = 3'd1;
    localparam logic [2:0] PH_SC1  = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_LCS  = 3'd4;
    localparam logic [2:0] PH_BODY = 3'd5;
    localparam logic [2:0] PH_DCS  = 3'd6;
    localparam logic [2:0] PH_POST = 3'd7;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_body_count, n_body_count;
    logic [7:0] r_running_sum, n_running_sum;
    logic [7:0] r_payload_limit;
    logic [7:0] sum_byte;
    logic [7:0] lcs_sum;
    logic [8:0] limit_plus_one;

    assign sum_byte       = r_running_sum + i_byte;
    assign lcs_sum        = r_frame_length + i_byte;
    assign limit_plus_one = {1'b0, r_payload_limit} + 9'd1;

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_body_count   = r_body_count;
        n_running_sum  = r_running_sum;
        o_has_result   = 1'b0;
        o_result       = '{kind: KIND_ERROR, data_byte: 8'd0,
                           payload_count: 8'd0, error_code: ERR_NONE};
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte != PREAMBLE_BYTE) begin
                    o_has_result        = 1'b1;
                    o_result.error_code = ERR_PREAMBLE;
                end else begin
                    n_phase = PH_SC0;
                end
            end
            PH_SC0: begin
                if (i_byte != START0_BYTE) begin
                    o_has_result        = 1'b1;
                    o_result.error_code = ERR_START;
                    n_phase             = PH_HUNT;
                end else begin
                    n_phase = PH_SC1;
                end
            end
            PH_SC1: begin
                if (i_byte != START1_BYTE) begin
                    o_has_result        = 1'b1;
                    o_result.error_code = ERR_START;
                    n_phase             = PH_HUNT;
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_frame_length = i_byte;
                n_phase        = PH_LCS;
            end
            PH_LCS: begin
                if (lcs_sum != 8'd0) begin
                    o_has_result        = 1'b1;
                    o_result.error_code = ERR_LCS;
                    n_phase             = PH_HUNT;
                end else if (r_frame_length == 8'd0
                             || {1'b0, r_frame_length} > limit_plus_one) begin
                    o_has_result        = 1'b1;
                    o_result.error_code = ERR_LENGTH;
                    n_phase             = PH_HUNT;
                end else begin
                    n_body_count  = 8'd0;
                    n_running_sum = 8'd0;
                    n_phase       = PH_BODY;
                end
            end
            PH_BODY: begin
                o_has_result       = 1'b1;
                o_result.kind      = (r_body_count == 8'd0) ? KIND_TFI : KIND_PAYLOAD;
                o_result.data_byte = i_byte;
                n_running_sum      = sum_byte;
                n_body_count       = r_body_count + 8'd1;
                if (n_body_count == r_frame_length) begin
                    n_phase = PH_DCS;
                end
            end
            PH_DCS: begin
                n_running_sum = sum_byte;
                n_phase       = PH_POST;
            end
            PH_POST: begin
                o_has_result = 1'b1;
                n_phase      = PH_HUNT;
                if (r_running_sum != 8'd0) begin
                    o_result.error_code = ERR_DCS;
                end else begin
                    o_result.kind          = KIND_GOOD;
                    o_result.payload_count = r_frame_length - 8'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_frame_length  <= 8'd0;
            r_body_count    <= 8'd0;
            r_running_sum   <= 8'd0;
            r_payload_limit <= LIMIT_RESET;
        end else begin
            if (i_take) begin
                r_phase        <= n_phase;
                r_frame_length <= n_frame_length;
                r_body_count   <= n_body_count;
                r_running_sum  <= n_running_sum;
            end
            if (i_cfg_wr_en) begin
                r_payload_limit <= i_cfg_wr_data;
            end
        end
    end

endmodule

[rtl/nfcd_out_reg.sv]
`timescale 1ns / 1ps

module nfcd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  nfcd_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output nfcd_pkg::t_result o_result
);
    import nfcd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

[tb/nfcd_frame_checker.sv]
`timescale 1ns / 1ps

module nfcd_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_payload_count,
    input  logic [2:0] i_error_code,
    output int         o_fail_count,
    output int         o_pending
);
    import nfcd_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_START0,
        ST_START1,
        ST_LEN,
        ST_LCS,
        ST_BODY,
        ST_DCS,
        ST_POST
    } t_parse_state;

    t_parse_state state = ST_HUNT;
    logic [7:0]   len_byte = 8'd0;
    logic [7:0]   body_cnt = 8'd0;
    logic [7:0]   data_sum = 8'd0;
    logic [7:0]   payload_limit = LIMIT_RESET;
    t_result      frame_results[$];
    int           fails = 0;

    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        logic [2:0] err;
        logic [7:0] len_check;
        bit         has;
        err                = ERR_NONE;
        has                = 1'b0;
        r.kind             = KIND_ERROR;
        r.data_byte        = 8'd0;
        r.payload_count    = 8'd0;
        r.error_code       = ERR_NONE;
        case (state)
            ST_HUNT: begin
                if (b != PREAMBLE_BYTE) err = ERR_PREAMBLE;
                else state = ST_START0;
            end
            ST_START0: begin
                if (b != START0_BYTE) err = ERR_START;
                else state = ST_START1;
            end
            ST_START1: begin
                if (b != START1_BYTE) err = ERR_START;
                else state = ST_LEN;
            end
            ST_LEN: begin
                len_byte = b;
                state    = ST_LCS;
            end
            ST_LCS: begin
                len_check = len_byte + b;
                if (len_check != 8'd0) begin
                    err = ERR_LCS;
                end else if (len_byte == 8'd0 ||
                             {1'b0, len_byte} > {1'b0, payload_limit} + 9'd1) begin
                    err = ERR_LENGTH;
                end else begin
                    body_cnt = 8'd0;
                    data_sum = 8'd0;
                    state    = ST_BODY;
                end
            end
            ST_BODY: begin
                r.kind      = (body_cnt == 8'd0) ? KIND_TFI : KIND_PAYLOAD;
                r.data_byte = b;
                has         = 1'b1;
                data_sum    = data_sum + b;
                body_cnt    = body_cnt + 8'd1;
                if (body_cnt == len_byte) state = ST_DCS;
            end
            ST_DCS: begin
                data_sum = data_sum + b;
                state    = ST_POST;
            end
            default: begin
                state = ST_HUNT;
                has   = 1'b1;
                if (data_sum != 8'd0) begin
                    r.error_code = ERR_DCS;
                end else begin
                    r.kind          = KIND_GOOD;
                    r.payload_count = len_byte - 8'd1;
                end
            end
        endcase
        if (err != ERR_NONE) begin
            state        = ST_HUNT;
            r.error_code = err;
            has          = 1'b1;
        end
        return has;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            state         = ST_HUNT;
            len_byte      = 8'd0;
            body_cnt      = 8'd0;
            data_sum      = 8'd0;
            payload_limit = LIMIT_RESET;
            frame_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.kind          = i_kind;
                seen.data_byte     = i_data_byte;
                seen.payload_count = i_payload_count;
                seen.error_code    = i_error_code;
                if (frame_results.size() == 0) begin
                    if (fails < 10)
                        $display({"%0t: result with none pending: ",
                                  "kind %0d data %02h count %0d err %0d"},
                                 $realtime, seen.kind, seen.data_byte, seen.payload_count,
                                 seen.error_code);
                    fails++;
                end else begin
                    want = frame_results.pop_front();
                    if (seen.kind != want.kind || seen.data_byte != want.data_byte ||
                        seen.payload_count != want.payload_count ||
                        seen.error_code != want.error_code) begin
                        if (fails < 10)
                            $display({"%0t: result mismatch: expected kind %0d data %02h ",
                                      "count %0d err %0d, got kind %0d data %02h count %0d err %0d"},
                                     $realtime, want.kind, want.data_byte, want.payload_count,
                                     want.error_code, seen.kind, seen.data_byte,
                                     seen.payload_count, seen.error_code);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_byte(i_rx_byte, want)) frame_results.push_back(want);
            end
            if (i_cfg_wr_en) payload_limit = i_cfg_wr_data;
        end
        o_pending    <= frame_results.size();
        o_fail_count <= fails;
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import nfcd_pkg::*;

    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        FLAW_NONE,
        FLAW_START0,
        FLAW_START1,
        FLAW_LCS,
        FLAW_DCS
    } t_frame_flaw;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_payload_count;
    logic [2:0] o_error_code;

    int         fail_count;
    int         results_pending;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         hold_seq = 0;
    int         hold_taken = 0;
    int         hold_left = 0;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    logic [7:0] cur_limit = LIMIT_RESET;

    int         idle_plan[5]  = '{0, 80, 0, 6, 0};
    int         stall_plan[5] = '{0, 0, 80, 6, 0};
    logic [7:0] limit_plan[5] = '{8'd1, 8'd255, 8'd0, 8'd100, 8'd254};

    nfc_frame_deframer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_payload_count (o_payload_count),
        .o_error_code    (o_error_code)
    );

    nfcd_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_kind          (o_kind),
        .i_data_byte     (o_data_byte),
        .i_payload_count (o_payload_count),
        .i_error_code    (o_error_code),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_seq != hold_taken) begin
            hold_taken  <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] len, input t_frame_flaw flaw);
        logic [7:0] lcs;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] dcs;
        send_byte(PREAMBLE_BYTE);
        send_byte(flaw == FLAW_START0 ? 8'($urandom_range(1, 255)) : START0_BYTE);
        send_byte(flaw == FLAW_START1 ? 8'($urandom_range(0, 254)) : START1_BYTE);
        send_byte(len);
        lcs = 8'd0 - len;
        if (flaw == FLAW_LCS) lcs = lcs + 8'($urandom_range(1, 255));
        send_byte(lcs);
        sum = 8'd0;
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(255));
            sum = sum + b;
            send_byte(b);
        end
        dcs = 8'd0 - sum;
        if (flaw == FLAW_DCS) dcs = dcs + 8'($urandom_range(1, 255));
        send_byte(dcs);
        send_byte(8'($urandom_range(255)));
    endtask

    // mostly short frames, a few at or past the length limit, a few zero
    function automatic logic [7:0] pick_len();
        int r;
        int top_len;
        r       = $urandom_range(99);
        top_len = int'(cur_limit) + 1;
        if (top_len > 255) top_len = 255;
        if (r < 3) return 8'd0;
        if (r < 8 && top_len < 255) return 8'($urandom_range(top_len + 1, 255));
        if (r < 12) return 8'($urandom_range(1, top_len));
        return 8'($urandom_range(1, (top_len < 8) ? top_len : 8));
    endfunction

    initial begin
        int r;
        int stop_at;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while hunting, then a TFI-only frame
        send_byte(8'hA5);
        send_frame(8'd1, FLAW_NONE);
        // second start code byte wrong
        send_byte(PREAMBLE_BYTE);
        send_byte(START0_BYTE);
        send_byte(8'h00);
        // length checksum wrong
        send_byte(PREAMBLE_BYTE);
        send_byte(START0_BYTE);
        send_byte(START1_BYTE);
        send_byte(8'h02);
        send_byte(8'h00);
        // zero length with a matching checksum
        send_byte(PREAMBLE_BYTE);
        send_byte(START0_BYTE);
        send_byte(START1_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_frame(8'd1, FLAW_DCS);

        for (int p = 0; p < 5; p++) begin
            wait_drain();
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            cur_limit = (p == 3) ? 8'($urandom_range(2, 253)) : limit_plan[p];
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= cur_limit;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            stop_at = bytes_sent + PHASE_BYTES;
            while (bytes_sent < stop_at) begin
                r = $urandom_range(99);
                if (r < 6) repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                else if (r < 70) send_frame(pick_len(), FLAW_NONE);
                else if (r < 82) send_frame(pick_len(), FLAW_DCS);
                else if (r < 88) send_frame(pick_len(), FLAW_LCS);
                else if (r < 94) send_frame(pick_len(), FLAW_START0);
                else send_frame(pick_len(), FLAW_START1);
            end
        end

        // back up the output side until the input stalls
        idle_pct = 0;
        hold_seq++;
        send_frame(8'd64, FLAW_NONE);
        wait_drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
